/* src/gle_pkg.sv */
package gle_pkg;

  localparam int DICT_ENTRIES_D  = 4096;
  localparam int HASH_SLOTS_D    = 8192;
  localparam int MAX_CODE_BITS_D = 12;

  localparam int          KEY_W    = 20;
  localparam int          PFX_W    = 12;
  localparam int          PIX_W    = 8;
  localparam int          ACC_W    = 20;
  localparam int          CNT_W    = 5;
  localparam int          CW_W     = 4;
  localparam int          TOP_W    = 16;
  localparam int          EPOCH_W  = 8;
  localparam int          CFG_W    = 16;
  localparam int          CFG_AW   = 2;
  localparam logic [31:0] GOLDEN   = 32'h9E37_79B9;

  localparam logic [CFG_AW-1:0] REG_CODE_SIZE  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_CLEAR_AT   = 2'd1;
  localparam logic [CFG_AW-1:0] REG_LEAD_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    SEL_PREFIX = 2'd0,
    SEL_CLEAR  = 2'd1,
    SEL_EOI    = 2'd2
  } code_sel_t;

  typedef struct packed {
    logic      latch;
    logic      start;
    logic      hash_mul;
    logic      hash_off;
    logic      slot_rd;
    logic      key_rd;
    logic      probe_next;
    logic      set_hit;
    logic      emit;
    code_sel_t sel;
    logic      drain;
    logic      drain_final;
    logic      update;
    logic      ins_slot;
    logic      clr_rst;
    logic      flush;
    logic      stream_end;
    logic      sweep_step;
  } dp_cmd_t;

  typedef struct packed {
    logic started;
    logic last;
    logic force_emit;
    logic lead;
    logic slot_empty;
    logic key_match;
    logic exhausted;
    logic top_at_clear;
    logic cnt_ge8;
    logic cnt_eq8;
    logic cnt_zero;
    logic out_free;
    logic epoch_wrap;
    logic sweep_done;
  } dp_stat_t;

endpackage

/* src/gif_lzw_encoder.sv */
// A first pixel of a stream is latched and starts a new dictionary, then its codes go out;
// any other is latched, hashed and offset, then its slot is read and checked, its key
// compared, with another slot per further probe; on a miss or force codes are emitted and
// drained byte by byte as the output takes them before a dictionary update or reset. No new
// pixel is taken until the last is through. Reset is synchronous, active low; then a clearing
// pass over the hash slots precedes the first pixel and recurs every 255 dictionary resets.
module gif_lzw_encoder #(
  parameter int DICT_ENTRIES  = gle_pkg::DICT_ENTRIES_D,
  parameter int HASH_SLOTS    = gle_pkg::HASH_SLOTS_D,
  parameter int MAX_CODE_BITS = gle_pkg::MAX_CODE_BITS_D
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [gle_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [gle_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // pixel
  input  logic                       in_tuser,   // force_emit
  input  logic                       in_tlast,   // stream_end
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata,  // code_byte
  output logic                       out_tlast   // final_byte
);

  gle_pkg::dp_cmd_t  cmd;
  gle_pkg::dp_stat_t stat;

  gle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gle_dp #(
    .DICT_ENTRIES  (DICT_ENTRIES),
    .HASH_SLOTS    (HASH_SLOTS),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .in_pixel    (in_tdata),
    .in_force    (in_tuser),
    .in_last     (in_tlast),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_byte    (out_tdata),
    .out_final   (out_tlast),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

/* src/gle_ctrl.sv */
module gle_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  gle_pkg::dp_stat_t stat,
  output gle_pkg::dp_cmd_t  cmd
);

  typedef enum logic [13:0] {
    ST_SWEEP   = 14'b00000000000001,
    ST_IDLE    = 14'b00000000000010,
    ST_START   = 14'b00000000000100,
    ST_HASH    = 14'b00000000001000,
    ST_OFFS    = 14'b00000000010000,
    ST_RDSLOT  = 14'b00000000100000,
    ST_CHKSLOT = 14'b00000001000000,
    ST_CHKKEY  = 14'b00000010000000,
    ST_EMIT    = 14'b00000100000000,
    ST_DRAIN   = 14'b00001000000000,
    ST_UPDATE  = 14'b00010000000000,
    ST_CLRRST  = 14'b00100000000000,
    ST_FLUSH   = 14'b01000000000000,
    ST_AFTER   = 14'b10000000000000
  } state_t;

  typedef enum logic [5:0] {
    PH_LEAD  = 6'b000001,
    PH_MISS  = 6'b000010,
    PH_CLR   = 6'b000100,
    PH_TAILP = 6'b001000,
    PH_TAILE = 6'b010000,
    PH_DONE  = 6'b100000
  } phase_t;

  state_t state_r, state_nxt;
  phase_t ph_r, ph_nxt, tail;
  logic   empty_r, empty_nxt;

  assign in_tready = (state_r == ST_IDLE);
  assign tail      = stat.last ? PH_TAILP : PH_DONE;

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    empty_nxt = empty_r;
    cmd       = '0;
    cmd.sel   = gle_pkg::SEL_PREFIX;
    cmd.ins_slot = empty_r;
    case (ph_r)
      PH_LEAD, PH_CLR: cmd.sel = gle_pkg::SEL_CLEAR;
      PH_TAILE:        cmd.sel = gle_pkg::SEL_EOI;
      default:         cmd.sel = gle_pkg::SEL_PREFIX;
    endcase
    case (state_r)
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_done) state_nxt = ST_AFTER;
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = stat.started ? ST_HASH : ST_START;
        end
      end
      ST_START: begin
        cmd.start = 1'b1;
        ph_nxt    = stat.lead ? PH_LEAD : tail;
        state_nxt = stat.epoch_wrap ? ST_SWEEP : ST_AFTER;
      end
      ST_HASH: begin
        cmd.hash_mul = 1'b1;
        state_nxt    = ST_OFFS;
      end
      ST_OFFS: begin
        cmd.hash_off = 1'b1;
        state_nxt    = ST_RDSLOT;
      end
      ST_RDSLOT: begin
        cmd.slot_rd = 1'b1;
        state_nxt   = ST_CHKSLOT;
      end
      ST_CHKSLOT: begin
        if (stat.slot_empty) begin
          empty_nxt = 1'b1;
          ph_nxt    = PH_MISS;
          state_nxt = ST_EMIT;
        end else begin
          cmd.key_rd = 1'b1;
          state_nxt  = ST_CHKKEY;
        end
      end
      ST_CHKKEY: begin
        if (stat.key_match && !stat.force_emit) begin
          cmd.set_hit = 1'b1;
          ph_nxt      = tail;
          state_nxt   = ST_AFTER;
        end else if (stat.key_match || stat.exhausted) begin
          empty_nxt = 1'b0;
          ph_nxt    = PH_MISS;
          state_nxt = ST_EMIT;
        end else begin
          cmd.probe_next = 1'b1;
          state_nxt      = ST_RDSLOT;
        end
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (stat.cnt_ge8) begin
          if (stat.out_free) begin
            cmd.drain       = 1'b1;
            cmd.drain_final = (ph_r == PH_TAILE) && stat.cnt_eq8;
          end
        end else begin
          case (ph_r)
            PH_LEAD: begin
              ph_nxt    = tail;
              state_nxt = ST_AFTER;
            end
            PH_MISS: begin
              if (stat.top_at_clear) begin
                ph_nxt    = PH_CLR;
                state_nxt = ST_EMIT;
              end else begin
                state_nxt = ST_UPDATE;
              end
            end
            PH_CLR:   state_nxt = ST_CLRRST;
            PH_TAILP: begin
              ph_nxt    = PH_TAILE;
              state_nxt = ST_EMIT;
            end
            PH_TAILE: state_nxt = ST_FLUSH;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        ph_nxt     = tail;
        state_nxt  = ST_AFTER;
      end
      ST_CLRRST: begin
        cmd.clr_rst = 1'b1;
        ph_nxt      = tail;
        state_nxt   = stat.epoch_wrap ? ST_SWEEP : ST_AFTER;
      end
      ST_FLUSH: begin
        if (stat.cnt_zero) begin
          cmd.stream_end = 1'b1;
          state_nxt      = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.flush      = 1'b1;
          cmd.stream_end = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_AFTER: begin
        state_nxt = (ph_r == PH_DONE) ? ST_IDLE : ST_EMIT;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
      ph_r    <= PH_DONE;
      empty_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      empty_r <= empty_nxt;
    end
  end

endmodule

/* src/gle_dp.sv */
module gle_dp #(
  parameter int DICT_ENTRIES  = gle_pkg::DICT_ENTRIES_D,
  parameter int HASH_SLOTS    = gle_pkg::HASH_SLOTS_D,
  parameter int MAX_CODE_BITS = gle_pkg::MAX_CODE_BITS_D
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [gle_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [gle_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic [gle_pkg::PIX_W-1:0]   in_pixel,
  input  logic                        in_force,
  input  logic                        in_last,
  input  logic                        out_tready,
  output logic                        out_tvalid,
  output logic [7:0]                  out_byte,
  output logic                        out_final,
  input  gle_pkg::dp_cmd_t            cmd,
  output gle_pkg::dp_stat_t           stat
);

  localparam int HB   = $clog2(HASH_SLOTS);
  localparam int IW   = $clog2(DICT_ENTRIES);
  localparam int SCW  = $clog2(DICT_ENTRIES + 1);
  localparam int SW_W = gle_pkg::EPOCH_W + SCW;
  localparam logic [HB-1:0]             SLOT_LAST  = HB'(HASH_SLOTS - 1);
  localparam logic [gle_pkg::TOP_W:0]   DICT_LIM   = (gle_pkg::TOP_W + 1)'(DICT_ENTRIES);
  localparam logic [gle_pkg::TOP_W:0]   CODE_LIM   = (gle_pkg::TOP_W + 1)'(1) << MAX_CODE_BITS;
  localparam logic [gle_pkg::CW_W-1:0]  CW_MAX     = gle_pkg::CW_W'(MAX_CODE_BITS);

  logic [SW_W-1:0]          slot_mem [HASH_SLOTS];
  logic [gle_pkg::KEY_W-1:0] key_mem [DICT_ENTRIES];

  logic [3:0]                   code_size_r;
  logic [gle_pkg::TOP_W-1:0]    clear_at_r;
  logic                         lead_r;
  logic [gle_pkg::PIX_W-1:0]    pix_r;
  logic                         force_r, last_r, started_r;
  logic [gle_pkg::PFX_W-1:0]    prefix_r;
  logic [gle_pkg::CW_W-1:0]     cw_r;
  logic [gle_pkg::TOP_W-1:0]    top_r;
  logic [gle_pkg::EPOCH_W-1:0]  epoch_r;
  logic [31:0]                  prod_r;
  logic [HB-1:0]                off_r, stride_r, probe_cnt_r, sweep_r;
  logic [SW_W-1:0]              slot_q_r;
  logic [gle_pkg::KEY_W-1:0]    key_q_r;
  logic [gle_pkg::ACC_W-1:0]    acc_r;
  logic [gle_pkg::CNT_W-1:0]    cnt_r;
  logic                         ovalid_r, ofinal_r;
  logic [7:0]                   obyte_r;

  logic [3:0]                   cs;
  logic [8:0]                   clr_code, eoi_code;
  logic [gle_pkg::KEY_W-1:0]    key;
  logic [HB-1:0]                off0;
  logic [SCW-1:0]               slot_code;
  logic [gle_pkg::PFX_W-1:0]    emit_code, emit_mask;
  logic [gle_pkg::TOP_W-1:0]    top_inc;
  logic                         ins_ok, grow_cw, out_free;
  logic                         slot_we;
  logic [HB-1:0]                slot_wa;
  logic [SW_W-1:0]              slot_wd;

  function automatic logic [31:0] GOLDEN_MUL(input logic [gle_pkg::KEY_W-1:0] k);
    logic [31:0] p;
    p = gle_pkg::GOLDEN * 32'(k);
    return p;
  endfunction

  always_comb begin
    if (code_size_r < 4'd2)      cs = 4'd2;
    else if (code_size_r > 4'd8) cs = 4'd8;
    else                         cs = code_size_r;
  end

  assign clr_code  = 9'd1 << cs;
  assign eoi_code  = clr_code + 9'd1;
  assign key       = {prefix_r, pix_r};
  assign off0      = prod_r[31 -: HB];
  assign slot_code = slot_q_r[SCW-1:0];
  assign top_inc   = top_r + gle_pkg::TOP_W'(1);
  assign ins_ok    = ({1'b0, top_inc} > (gle_pkg::TOP_W + 1)'(eoi_code)) &&
                     ({1'b0, top_inc} < DICT_LIM) && ({1'b0, top_inc} < CODE_LIM);
  assign grow_cw   = ({1'b0, top_inc} >= ((gle_pkg::TOP_W + 1)'(1) << cw_r)) &&
                     (cw_r < CW_MAX);
  assign emit_mask = gle_pkg::PFX_W'(((gle_pkg::PFX_W + 1)'(1) << cw_r) - 1'b1);
  assign out_free  = !ovalid_r || out_tready;

  always_comb begin
    case (cmd.sel)
      gle_pkg::SEL_CLEAR: emit_code = gle_pkg::PFX_W'(clr_code);
      gle_pkg::SEL_EOI:   emit_code = gle_pkg::PFX_W'(eoi_code);
      default:            emit_code = prefix_r;
    endcase
  end

  assign stat.started      = started_r;
  assign stat.last         = last_r;
  assign stat.force_emit   = force_r;
  assign stat.lead         = lead_r;
  assign stat.slot_empty   = (slot_q_r[SW_W-1 -: gle_pkg::EPOCH_W] != epoch_r) ||
                             (slot_code == '0);
  assign stat.key_match    = (key_q_r == key);
  assign stat.exhausted    = (probe_cnt_r == SLOT_LAST);
  assign stat.top_at_clear = (top_r == clear_at_r);
  assign stat.cnt_ge8      = (cnt_r >= 5'd8);
  assign stat.cnt_eq8      = (cnt_r == 5'd8);
  assign stat.cnt_zero     = (cnt_r == '0);
  assign stat.out_free     = out_free;
  assign stat.epoch_wrap   = (epoch_r == '1);
  assign stat.sweep_done   = (sweep_r == SLOT_LAST);

  assign out_tvalid = ovalid_r;
  assign out_byte   = obyte_r;
  assign out_final  = ofinal_r;

  always_comb begin
    slot_we = 1'b0;
    slot_wa = off_r;
    slot_wd = {epoch_r, SCW'(top_inc + gle_pkg::TOP_W'(1))};
    if (cmd.sweep_step) begin
      slot_we = 1'b1;
      slot_wa = sweep_r;
      slot_wd = '0;
    end else if (cmd.update && ins_ok && cmd.ins_slot) begin
      slot_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    if (cmd.slot_rd) slot_q_r <= slot_mem[off_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.update && ins_ok) key_mem[top_inc[IW-1:0]] <= key;
    if (cmd.key_rd) key_q_r <= key_mem[IW'(slot_code - SCW'(1))];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      pix_r   <= in_pixel & gle_pkg::PIX_W'(clr_code - 9'd1);
      force_r <= in_force;
      last_r  <= in_last;
    end
    if (cmd.hash_mul) prod_r <= GOLDEN_MUL(key);
    if (cmd.hash_off) begin
      off_r    <= off0;
      stride_r <= (off0 == '0) ? HB'(1) : (~off0 + HB'(1));
    end
    if (cmd.probe_next) off_r <= off_r - stride_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_size_r <= 4'd8;
      clear_at_r  <= 16'd4095;
      lead_r      <= 1'b1;
      started_r   <= 1'b0;
      prefix_r    <= '0;
      cw_r        <= 4'd9;
      top_r       <= 16'd257;
      epoch_r     <= gle_pkg::EPOCH_W'(1);
      probe_cnt_r <= '0;
      sweep_r     <= '0;
      acc_r       <= '0;
      cnt_r       <= '0;
      ovalid_r    <= 1'b0;
      ofinal_r    <= 1'b0;
      obyte_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          gle_pkg::REG_CODE_SIZE:  code_size_r <= cfg_wr_data[3:0];
          gle_pkg::REG_CLEAR_AT:   clear_at_r  <= cfg_wr_data;
          gle_pkg::REG_LEAD_CLEAR: lead_r      <= cfg_wr_data[0];
          default: ;
        endcase
      end
      if (cmd.sweep_step) sweep_r <= sweep_r + HB'(1);
      if (cmd.hash_off) probe_cnt_r <= '0;
      if (cmd.probe_next) probe_cnt_r <= probe_cnt_r + HB'(1);
      if (cmd.start || cmd.clr_rst) begin
        cw_r     <= cs + 4'd1;
        top_r    <= gle_pkg::TOP_W'(eoi_code);
        prefix_r <= gle_pkg::PFX_W'(pix_r);
        epoch_r  <= (epoch_r == '1) ? gle_pkg::EPOCH_W'(1) : epoch_r + gle_pkg::EPOCH_W'(1);
      end
      if (cmd.start) started_r <= 1'b1;
      if (cmd.set_hit) prefix_r <= gle_pkg::PFX_W'(slot_code - SCW'(1));
      if (cmd.update) begin
        top_r    <= top_inc;
        prefix_r <= gle_pkg::PFX_W'(pix_r);
        if (grow_cw) cw_r <= cw_r + 4'd1;
      end
      if (cmd.stream_end) started_r <= 1'b0;

      if (cmd.drain || cmd.flush) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
      if (cmd.emit) begin
        acc_r <= acc_r | (gle_pkg::ACC_W'(emit_code & emit_mask) << cnt_r);
        cnt_r <= cnt_r + gle_pkg::CNT_W'(cw_r);
      end
      if (cmd.drain) begin
        obyte_r  <= acc_r[7:0];
        ofinal_r <= cmd.drain_final;
        acc_r    <= acc_r >> 8;
        cnt_r    <= cnt_r - 5'd8;
      end
      if (cmd.flush) begin
        obyte_r  <= acc_r[7:0];
        ofinal_r <= 1'b1;
        acc_r    <= '0;
        cnt_r    <= '0;
      end
    end
  end

endmodule

/* dv/tb_top.sv */
module tb_top;

  typedef struct {
    logic [7:0] pix;
    logic       frc;
    logic       eos;
  } pixel_word_t;

  typedef struct {
    logic [7:0] code_byte;
    logic       fin;
  } byte_word_t;

  localparam int HS = gle_pkg::HASH_SLOTS_D;
  localparam int DE = gle_pkg::DICT_ENTRIES_D;
  localparam int MAXW = gle_pkg::MAX_CODE_BITS_D;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_wr_en = 1'b0;
  logic [gle_pkg::CFG_AW-1:0] cfg_addr = gle_pkg::REG_CODE_SIZE;
  logic [gle_pkg::CFG_W-1:0]  cfg_wr_data = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = '0;  // pixel
  logic              in_tuser = 1'b0;  // force_emit
  logic              in_tlast = 1'b0;  // stream_end
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;  // code_byte
  logic              out_tlast;  // final_byte

  gif_lzw_encoder dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [3:0]  cs_reg;
  logic [15:0] clear_at_reg;
  logic        lead_reg;
  logic [19:0] acc;
  logic [4:0]  nbits;
  logic [3:0]  cw;
  logic [15:0] top;
  logic [11:0] prefix;
  logic        started;
  logic [19:0] dict_keys [DE];
  logic [12:0] slots [HS];

  pixel_word_t pix_q[$];
  byte_word_t  bytes_q[$];
  int errors = 0;
  int issued = 0;
  int accepted = 0;
  int send_idle = 0;
  int recv_idle = 0;
  logic hold = 1'b0;
  logic hold_go = 1'b0;

  function automatic int root_size();
    if (cs_reg < 2) return 2;
    if (cs_reg > 8) return 8;
    return cs_reg;
  endfunction

  function automatic void wipe_slots();
    for (int i = 0; i < HS; i++) slots[i] = '0;
  endfunction

  function automatic void stream_restart();
    acc = '0;
    nbits = '0;
    cw = 4'(root_size() + 1);
    top = 16'((1 << root_size()) + 1);
    prefix = '0;
    started = 1'b0;
    wipe_slots();
  endfunction

  function automatic void pack_code(input logic [15:0] code);
    logic [19:0] masked;
    masked = 20'(code) & ((20'd1 << cw) - 20'd1);
    acc = acc | (masked << nbits);
    nbits = nbits + 5'(cw);
    while (nbits >= 8) begin
      bytes_q.insert(bytes_q.size(), byte_word_t'{acc[7:0], 1'b0});
      acc = acc >> 8;
      nbits = nbits - 5'd8;
    end
  endfunction

  // 1 hit, 0 miss with free slot, 2 miss with no slot
  function automatic int lookup(input logic [19:0] key, output logic [11:0] code,
                                output logic [12:0] slot);
    logic [31:0] prod;
    int off, stride;
    prod = gle_pkg::GOLDEN * {12'd0, key};
    off = int'(prod[31:19]) % HS;
    stride = (off == 0) ? 1 : HS - off;
    code = '0;
    slot = '0;
    for (int i = 0; i < HS; i++) begin
      if (slots[off] == 0) begin
        slot = 13'(off);
        return 0;
      end
      if (int'(slots[off]) - 1 < DE && dict_keys[slots[off] - 1] == key) begin
        code = 12'(slots[off] - 1);
        return 1;
      end
      off = (off + HS - stride) % HS;
    end
    return 2;
  endfunction

  function automatic void predict_bytes(input pixel_word_t w);
    int cs, clr, eoi, r, n0;
    logic [7:0] pix;
    logic [19:0] key;
    logic [11:0] code;
    logic [12:0] slot;
    cs = root_size();
    clr = 1 << cs;
    eoi = clr + 1;
    pix = w.pix & 8'(clr - 1);
    n0 = bytes_q.size();
    if (!started) begin
      wipe_slots();
      cw = 4'(cs + 1);
      top = 16'(eoi);
      if (lead_reg) pack_code(16'(clr));
      prefix = 12'(pix);
      started = 1'b1;
    end else begin
      key = {prefix, pix};
      r = lookup(key, code, slot);
      if (r == 1 && !w.frc) begin
        prefix = code;
      end else begin
        pack_code(16'(prefix));
        if (top == clear_at_reg) begin
          pack_code(16'(clr));
          cw = 4'(cs + 1);
          top = 16'(eoi);
          wipe_slots();
        end else begin
          top = top + 16'd1;
          if (top > eoi && top < DE && top < (1 << MAXW)) begin
            dict_keys[top] = key;
            if (r == 0) slots[slot] = 13'(top + 1);
          end
          if (top >= (17'd1 << cw) && cw < MAXW) cw = cw + 4'd1;
        end
        prefix = 12'(pix);
      end
    end
    if (w.eos) begin
      pack_code(16'(prefix));
      pack_code(16'(eoi));
      if (nbits > 0) bytes_q.insert(bytes_q.size(), byte_word_t'{acc[7:0], 1'b0});
      if (bytes_q.size() > n0) bytes_q[bytes_q.size() - 1].fin = 1'b1;
      stream_restart();
    end
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || accepted == issued)) begin
      if (pix_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_tvalid <= 1'b1;
        in_tdata <= pix_q[0].pix;
        in_tuser <= pix_q[0].frc;
        in_tlast <= pix_q[0].eos;
        void'(pix_q.pop_front());
        issued <= issued + 1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= !hold && ($urandom_range(99) >= recv_idle);
  end

  // monitor
  always @(posedge clk) begin
    byte_word_t e;
    if (in_tvalid && in_tready) begin
      predict_bytes(pixel_word_t'{in_tdata, in_tuser, in_tlast});
      accepted <= accepted + 1;
    end
    if (out_tvalid && out_tready) begin
      if (bytes_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h last %b", out_tdata, out_tlast);
      end else begin
        e = bytes_q.pop_front();
        if (e.code_byte !== out_tdata || e.fin !== out_tlast) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %h last %b, got %h last %b",
                     e.code_byte, e.fin, out_tdata, out_tlast);
        end
      end
    end
  end

  initial begin
    wait (hold_go);
    hold = 1'b1;
    repeat (400) @(negedge clk);
    hold = 1'b0;
  end

  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 600000) begin
        $display("gif_lzw_encoder test failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [gle_pkg::CFG_AW-1:0] a,
                           input logic [gle_pkg::CFG_W-1:0] d);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_addr = a;
    cfg_wr_data = d;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (a == gle_pkg::REG_CODE_SIZE) cs_reg = d[3:0];
    else if (a == gle_pkg::REG_CLEAR_AT) clear_at_reg = d;
    else lead_reg = d[0];
  endtask

  task automatic setup(input logic [3:0] cs, input logic [15:0] ca, input logic ld);
    write_reg(gle_pkg::REG_CODE_SIZE, 16'(cs));
    write_reg(gle_pkg::REG_CLEAR_AT, ca);
    write_reg(gle_pkg::REG_LEAD_CLEAR, 16'(ld));
    stream_restart();
  endtask

  task automatic push(input logic [7:0] p, input logic f, input logic e);
    pix_q.insert(pix_q.size(), pixel_word_t'{p, f, e});
  endtask

  task automatic drain();
    wait (pix_q.size() == 0 && accepted == issued && bytes_q.size() == 0);
    repeat (60) @(negedge clk);
  endtask

  task automatic random_stream(input int count, input int alpha);
    logic [7:0] p;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) p = 8'($urandom);
      else p = 8'($urandom_range(alpha));
      push(p, $urandom_range(14) == 0, i == count - 1 || $urandom_range(39) == 0);
    end
  endtask

  initial begin
    cs_reg = 4'd8;
    clear_at_reg = 16'd4095;
    lead_reg = 1'b1;
    for (int i = 0; i < DE; i++) dict_keys[i] = '0;
    stream_restart();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle = 10;
    recv_idle = 52;
    // reset settings, directed
    push(8'd0, 1'b1, 1'b1);
    push(8'd255, 1'b0, 1'b1);
    push(8'd255, 1'b1, 1'b0);
    push(8'd0, 1'b0, 1'b0);
    push(8'd255, 1'b0, 1'b0);
    push(8'd0, 1'b0, 1'b0);
    push(8'd255, 1'b0, 1'b0);
    push(8'd0, 1'b1, 1'b0);
    push(8'd255, 1'b1, 1'b0);
    push(8'd0, 1'b0, 1'b0);
    push(8'd255, 1'b0, 1'b0);
    push(8'h55, 1'b0, 1'b0);
    push(8'hAA, 1'b0, 1'b0);
    push(8'h55, 1'b0, 1'b0);
    push(8'hAA, 1'b1, 1'b1);
    drain();
    // too-wide pixels, small roots, out-of-range sizes
    setup(4'd0, 16'd7, 1'b0);
    push(8'hFF, 1'b0, 1'b0);
    push(8'hFE, 1'b0, 1'b0);
    push(8'h03, 1'b0, 1'b0);
    push(8'h07, 1'b1, 1'b0);
    push(8'h02, 1'b0, 1'b0);
    push(8'h01, 1'b0, 1'b1);
    drain();
    setup(4'd15, 16'd0, 1'b1);
    push(8'd1, 1'b0, 1'b0);
    push(8'd1, 1'b0, 1'b0);
    push(8'd1, 1'b0, 1'b1);
    drain();

    setup(4'd2, 16'd20, 1'b1);
    hold_go = 1'b1;
    random_stream(70, 3);
    drain();

    send_idle = 52;
    recv_idle = 10;
    setup(4'd3, 16'd9, 1'b0);
    random_stream(50, 7);
    drain();
    setup(4'd8, 16'd65535, 1'b0);
    random_stream(70, 3);
    drain();

    send_idle = 0;
    recv_idle = 0;
    setup(4'd4, 16'd40, 1'b1);
    random_stream(60, 15);
    drain();
    setup(4'd9, 16'd300, 1'b1);
    random_stream(96, 2);
    drain();

    errors += bytes_q.size();
    if (errors == 0) $display("gif_lzw_encoder test passed");
    else $display("gif_lzw_encoder test failed");
    $finish;
  end
endmodule

/* sim.f */
src/gle_pkg.sv
src/gle_ctrl.sv
src/gle_dp.sv
src/gif_lzw_encoder.sv
dv/tb_top.sv
